>>> rtl/core/line_endpoint_detector_top_assert.svh
// Assertion macros for the line endpoint detector; empty under synthesis.
`ifndef LINE_ENDPOINT_DETECTOR_TOP_ASSERT_SVH
`define LINE_ENDPOINT_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LED_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("line endpoint detector assertion failed");
`define LED_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("line endpoint detector forbidden condition seen");
`else
`define LED_ASSERT(label, prop)
`define LED_ASSERT_NEVER(label, cond)
`endif

`endif

>>> rtl/core/led_pkg.sv
// Shared constants and types for the line endpoint detector.
`timescale 1ns / 1ps

package led_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int SIDE_DEPTH = 2;
    localparam int WIN        = 2 * SIDE_DEPTH + 2;
    localparam int LAG        = SIDE_DEPTH + 1;
    localparam int MAX_HEIGHT = 4096;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + LAG + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + LAG + 1);

    localparam int GRAY_W       = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_WHITE_W  = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int X_W          = 10;
    localparam int Y_W          = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WHITE_LEVEL  = 2'd2
    } cfg_reg_t;

    // One window column: bit m is the dark bit m rows above the newest row.
    typedef logic [WIN-1:0] col_bits_t;
    // Window column k holds the pixel column k places behind the newest one.
    typedef col_bits_t [WIN-1:0] window_t;
    // Row store entry: dark bits of the previous WIN-1 rows of one column.
    typedef logic [WIN-2:0] store_t;

endpackage

>>> rtl/core/led_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module led_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/line_endpoint_detector_top.sv
// Top level of the line endpoint detector: row store RAM, 6x6 window, endpoint test.
// Throughput is one pixel per cycle unless the output stalls or the row store is clearing.
// Per pixel the single row store RAM is read once and, for in-image pixels, written once.
// Results pass the stage 1 and output registers. After reset the row store is cleared, one
// entry per cycle; pixels are not accepted during that pass, configuration writes are.
`timescale 1ns / 1ps
`include "line_endpoint_detector_top_assert.svh"

module line_endpoint_detector_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [led_pkg::GRAY_W-1:0]            pixel_gray,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [led_pkg::X_W-1:0]               endpoint_x,
    output logic [led_pkg::Y_W-1:0]               endpoint_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [led_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [led_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // Configuration registers
    logic [led_pkg::CFG_WIDTH_W-1:0]  image_width_reg;
    logic [led_pkg::CFG_HEIGHT_W-1:0] image_height_reg;
    logic [led_pkg::CFG_WHITE_W-1:0]  white_level_reg;

    // Clearing pass
    logic                             clr_active_reg;
    logic [led_pkg::ADDR_W-1:0]       clr_cnt_reg;

    // Raster position counters
    logic [led_pkg::COL_W-1:0]        col_reg, col_next;
    logic [led_pkg::ROW_W-1:0]        row_reg, row_next;

    // Stage 1 (waits on the RAM read)
    logic                             s1_valid_reg;
    logic [led_pkg::COL_W-1:0]        s1_col_reg;
    logic [led_pkg::ROW_W-1:0]        s1_row_reg;
    logic                             s1_dark_reg;
    logic                             s1_inimg_reg;

    led_pkg::window_t                 win_reg, win_next;

    // Output register
    logic                             out_valid_reg;
    logic [led_pkg::X_W-1:0]          endpoint_x_reg;
    logic [led_pkg::Y_W-1:0]          endpoint_y_reg;

    // Combinational signals
    logic                             in_accept;
    logic                             s1_fire;
    logic                             out_free;
    logic [led_pkg::COL_W-1:0]        w_eff;
    logic [led_pkg::COL_W-1:0]        w_lim;
    logic [led_pkg::ROW_W-1:0]        h_eff;
    logic [led_pkg::ROW_W-1:0]        h_lim;
    logic [led_pkg::COL_W-1:0]        c_cur;
    logic [led_pkg::ROW_W-1:0]        r_tmp;
    logic [led_pkg::ROW_W-1:0]        r_cur;
    logic [led_pkg::COL_W-1:0]        c_inc;
    logic [led_pkg::ROW_W-1:0]        r_inc;
    logic                             d_cur;
    logic                             inimg_cur;

    logic                             ram_we;
    logic [led_pkg::ADDR_W-1:0]       ram_waddr;
    led_pkg::store_t                  ram_wdata;
    logic                             ram_re;
    logic [led_pkg::ADDR_W-1:0]       ram_raddr;
    led_pkg::store_t                  ram_rdata;

    led_pkg::col_bits_t               vec_full;
    led_pkg::col_bits_t               vec_new;
    logic                             gn, gs, gw, ge;
    logic                             p0, p1;
    logic [2:0]                       group_cnt;
    logic                             s1_hit;
    logic [led_pkg::COL_W-1:0]        cen_i;
    logic [led_pkg::COL_W-1:0]        end_x;
    logic [led_pkg::ROW_W-1:0]        cen_j;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= led_pkg::CFG_WIDTH_W'(1024);
            image_height_reg <= led_pkg::CFG_HEIGHT_W'(1024);
            white_level_reg  <= led_pkg::CFG_WHITE_W'(255);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                led_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[led_pkg::CFG_WIDTH_W-1:0];
                end
                led_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data[led_pkg::CFG_HEIGHT_W-1:0];
                end
                led_pkg::REG_WHITE_LEVEL:
                begin
                    white_level_reg <= cfg_data[led_pkg::CFG_WHITE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective frame size, with out-of-range register values clamped.
    always_comb
    begin
        priority if (image_width_reg == '0)
        begin
            w_eff = led_pkg::COL_W'(1);
        end
        else if (image_width_reg > led_pkg::CFG_WIDTH_W'(led_pkg::MAX_WIDTH))
        begin
            w_eff = led_pkg::COL_W'(led_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = led_pkg::COL_W'(image_width_reg);
        end

        priority if (image_height_reg == '0)
        begin
            h_eff = led_pkg::ROW_W'(1);
        end
        else if (image_height_reg > led_pkg::CFG_HEIGHT_W'(led_pkg::MAX_HEIGHT))
        begin
            h_eff = led_pkg::ROW_W'(led_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = led_pkg::ROW_W'(image_height_reg);
        end

        w_lim = w_eff + led_pkg::COL_W'(led_pkg::LAG);
        h_lim = h_eff + led_pkg::ROW_W'(led_pkg::LAG);
    end

    // Stage 0: locate the incoming pixel, then advance the counters.
    always_comb
    begin
        if (col_reg >= w_lim)
        begin
            c_cur = '0;
            r_tmp = row_reg + led_pkg::ROW_W'(1);
        end
        else
        begin
            c_cur = col_reg;
            r_tmp = row_reg;
        end
        r_cur = (r_tmp >= h_lim) ? '0 : r_tmp;

        d_cur     = (r_cur < h_eff) && (pixel_gray < white_level_reg);
        inimg_cur = (c_cur < w_eff);

        c_inc = c_cur + led_pkg::COL_W'(1);
        r_inc = r_cur + led_pkg::ROW_W'(1);
        if (c_inc >= w_lim)
        begin
            col_next = '0;
            row_next = (r_inc >= h_lim) ? '0 : r_inc;
        end
        else
        begin
            col_next = c_inc;
            row_next = r_cur;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_ready  = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign in_accept = in_valid && in_ready;

    // Consecutive items never share a column (a padded row has at least four),
    // so the stage 1 write and the next read never hit the same entry.
    assign ram_re    = in_accept;
    assign ram_raddr = c_cur[led_pkg::ADDR_W-1:0];
    assign ram_we    = clr_active_reg || (s1_fire && s1_inimg_reg);
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : s1_col_reg[led_pkg::ADDR_W-1:0];
    assign ram_wdata = clr_active_reg ? '0 : vec_full[led_pkg::WIN-2:0];

    led_ram #(
        .WIDTH (led_pkg::WIN - 1),
        .DEPTH (led_pkg::MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Stage 1: build the new window column and test the centre it completes.
    always_comb
    begin
        vec_full = {ram_rdata, s1_dark_reg};
        vec_new  = s1_inimg_reg ? vec_full : '0;
        // Rows above the top of the frame read as white.
        for (int m = 0; m < led_pkg::WIN; m++)
        begin
            if (s1_row_reg < led_pkg::ROW_W'(m))
            begin
                vec_new[m] = 1'b0;
            end
        end

        win_next[0] = vec_new;
        for (int k = 1; k < led_pkg::WIN; k++)
        begin
            win_next[k] = (s1_col_reg == '0) ? '0 : win_reg[k-1];
        end

        gn = 1'b0;
        gs = 1'b0;
        gw = 1'b0;
        ge = 1'b0;
        for (int n = 1; n <= led_pkg::SIDE_DEPTH; n++)
        begin
            gn = gn | win_next[led_pkg::LAG][led_pkg::LAG+n]
                    | win_next[led_pkg::LAG-1][led_pkg::LAG+n];
            gs = gs | win_next[led_pkg::LAG][led_pkg::LAG-n-1]
                    | win_next[led_pkg::LAG-1][led_pkg::LAG-n-1];
            gw = gw | win_next[led_pkg::LAG+n][led_pkg::LAG]
                    | win_next[led_pkg::LAG+n][led_pkg::LAG-1];
            ge = ge | win_next[led_pkg::LAG-n-1][led_pkg::LAG]
                    | win_next[led_pkg::LAG-n-1][led_pkg::LAG-1];
        end
        group_cnt = 3'(gn) + 3'(gs) + 3'(gw) + 3'(ge);
        p0 = win_next[led_pkg::LAG][led_pkg::LAG];
        p1 = win_next[led_pkg::LAG-1][led_pkg::LAG];

        s1_hit = (group_cnt == 3'd1) && (p0 ^ p1)
                 && (s1_col_reg >= led_pkg::COL_W'(led_pkg::LAG))
                 && (s1_row_reg >= led_pkg::ROW_W'(led_pkg::LAG));

        cen_i = s1_col_reg - led_pkg::COL_W'(led_pkg::LAG);
        cen_j = s1_row_reg - led_pkg::ROW_W'(led_pkg::LAG);
        end_x = p0 ? cen_i : cen_i + led_pkg::COL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            win_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + led_pkg::ADDR_W'(1);
                if (clr_cnt_reg == led_pkg::ADDR_W'(led_pkg::MAX_WIDTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                win_reg <= win_next;
            end

            if (out_free)
            begin
                out_valid_reg <= s1_fire && s1_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg   <= c_cur;
            s1_row_reg   <= r_cur;
            s1_dark_reg  <= d_cur;
            s1_inimg_reg <= inimg_cur;
        end
        if (s1_fire && s1_hit)
        begin
            endpoint_x_reg <= led_pkg::X_W'(end_x);
            endpoint_y_reg <= led_pkg::Y_W'(cen_j);
        end
    end

    assign out_valid  = out_valid_reg;
    assign endpoint_x = endpoint_x_reg;
    assign endpoint_y = endpoint_y_reg;

    `LED_ASSERT_NEVER(a_clear_no_item, clr_active_reg && s1_valid_reg)
    `LED_ASSERT_NEVER(a_no_rw_collision, ram_we && ram_re && (ram_waddr == ram_raddr))
    `LED_ASSERT(a_hit_reaches_output, (s1_fire && s1_hit) |=> out_valid_reg)

endmodule
